// ----- hdl/hough_line_accumulator_peak_core_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef HOUGH_LINE_ACCUMULATOR_PEAK_CORE_MACROS_SVH
`define HOUGH_LINE_ACCUMULATOR_PEAK_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define HLAP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HLAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/hlap_pkg.sv -----
`timescale 1ns / 1ps
package hlap_pkg;

    localparam int MAX_SIDE    = 128;
    localparam int THETA_COUNT = 180;

    localparam int CELL_W    = 15;
    localparam int SIN_W     = 21;
    localparam int SHADE_MAX = 255;
    localparam logic [CELL_W-1:0] CELL_MAX = '1;

    localparam logic [1:0] OP_VOTE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_VCOS,
        S_VSIN,
        S_VRHO,
        S_VADR,
        S_VRD,
        S_VWR,
        S_RCHK,
        S_RRD,
        S_RDAT,
        S_RDIV,
        S_DONE
    } t_state;

    typedef logic [SIN_W-1:0] t_sin_tab [0:90];

    // Shift-and-subtract quotient; only evaluated while the table is built.
    function automatic longint unsigned hlap_udiv(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave sine in Q(frac), from a Q30 Taylor series.
    function automatic t_sin_tab hlap_sin_table(input int frac);
        t_sin_tab          tab;
        longint unsigned   x;
        longint unsigned   term;
        longint unsigned   usum;
        longint            sum;
        for (int d = 0; d <= 90; d++) begin
            x    = hlap_udiv(64'(d) * 64'd3373259426, 64'd180);
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 8; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = hlap_udiv(term, 64'(2 * k) * 64'(2 * k + 1));
                if ((k % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            usum   = 64'(sum);
            tab[d] = SIN_W'((usum + (64'd1 << (29 - frac))) >> (30 - frac));
        end
        return tab;
    endfunction

endpackage

// ----- hdl/hlap_store.sv -----
`timescale 1ns / 1ps
module hlap_store #(
    parameter int DEPTH  = 65160,
    parameter int ADDR_W = 16,
    parameter int DATA_W = 15
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [0:DEPTH-1];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/hlap_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module hlap_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    assign fits   = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem  <= fits ? (rem_sh - {1'b0, r_den}) : rem_sh;
                r_quo  <= {r_quo[NUM_W-2:0], fits};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ----- hdl/hough_line_accumulator_peak_core.sv -----
`timescale 1ns / 1ps
// Channel  | direction | handshake                  | payload
// item     | in        | start & !busy              | i_op, i_pixel_col/row, i_is_black,
//          |           |                            | i_read_rho_row, i_read_theta
// result   | out       | o_valid, one cycle         | o_peak_*, o_any_votes, o_cell_*,
//          |           |                            | o_index_error
// config   | in        | i_cfg_we                   | i_cfg_wdata (rho offset)
//
// Vote, black pixel: per angle the shared multiplier is used three times, then a
//   read-modify-write on the store (one write port, one read port); an angle outside
//   the store skips the read-modify-write.
// Read: the shade is set by the bit-serial divider.
// Clear, and reset: a sweep over all ROW_COUNT*THETA_COUNT cells (65160 by default)
//   zeroes the store; busy stays high meanwhile.
// Results cannot be stalled: o_valid is high one cycle.
module hough_line_accumulator_peak_core #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_op,
    input  logic [6:0]        i_pixel_col,
    input  logic [6:0]        i_pixel_row,
    input  logic              i_is_black,
    input  logic [8:0]        i_read_rho_row,
    input  logic [7:0]        i_read_theta,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    output logic              o_valid,
    output logic [14:0]       o_peak_count,
    output logic [7:0]        o_peak_theta,
    output logic signed [8:0] o_peak_rho,
    output logic              o_any_votes,
    output logic [14:0]       o_cell_count,
    output logic [7:0]        o_cell_shade,
    output logic              o_index_error
);
    import hlap_pkg::*;

    `include "hough_line_accumulator_peak_core_macros.svh"

    localparam int ROW_COUNT  = 2 * ((MAX_SIDE * 1449) / 1024);
    localparam int CELL_COUNT = ROW_COUNT * THETA_COUNT;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROW_COUNT);
    localparam int B_W        = (ROW_W > 7) ? ROW_W : 7;
    localparam int TV_W       = TRIG_FRAC_BITS + 2;
    localparam int P_W        = TV_W + B_W + 1;
    localparam int S_W        = P_W + 1;
    localparam int I_W        = S_W + 1;
    localparam int T_W        = (THETA_COUNT > 1) ? $clog2(THETA_COUNT) : 1;
    localparam int NUM_W      = CELL_W + 9;
    localparam t_sin_tab SIN_TAB = hlap_sin_table(TRIG_FRAC_BITS);

    t_state r_state, n_state;

    // captured item
    logic [1:0]  r_op;
    logic [6:0]  r_col, r_row;
    logic        r_black;
    logic [8:0]  r_rrow;
    logic [7:0]  r_rth;
    logic        r_reply;

    logic [7:0]  r_rho_offset;

    // angle walk: t, and its quadrant / remainder mod 90
    logic [T_W-1:0] r_t;
    logic [1:0]     r_q;
    logic [6:0]     r_r;
    logic           last_t;

    // shared multiplier
    logic signed [TV_W-1:0] mul_a;
    logic [B_W-1:0]         mul_b;
    logic signed [P_W-1:0]  r_prod;
    logic signed [P_W-1:0]  r_acc;

    // rho / index
    logic signed [S_W-1:0]  sum;
    logic [S_W-1:0]         mag;
    logic [S_W-1:0]         rmag;
    logic signed [S_W-1:0]  rho;
    logic signed [I_W-1:0]  idx;
    logic                   idx_ok;
    logic signed [8:0]      r_rho;
    logic [B_W-1:0]         r_idx;
    logic                   r_ok;

    // trig lookup
    logic [1:0]             q_sel;
    logic [6:0]             tab_ix;
    logic signed [TV_W-1:0] tv_pos;
    logic signed [TV_W-1:0] tv;

    // store port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_clr;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] inc_val;

    // peak tracking
    logic [CELL_W-1:0] r_best_count;
    logic [7:0]        r_best_theta;
    logic signed [8:0] r_best_rho;
    logic              r_voted;

    // result word
    logic [CELL_W-1:0] r_cell;
    logic [7:0]        r_shade;
    logic              r_err;

    // shade divider
    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic              div_done;
    logic [NUM_W-1:0]  div_quo;

    logic              accept;
    logic              rd_range_bad;
    logic [15:0]       rrow_ext;
    logic [15:0]       t_ext;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign last_t  = (r_t == T_W'(THETA_COUNT - 1));
    assign t_ext   = 16'(r_t);
    assign rrow_ext = {7'd0, r_rrow};
    assign rd_range_bad = (rrow_ext >= 16'(ROW_COUNT)) || ({8'd0, r_rth} >= 16'(THETA_COUNT));

    // sine of the current quadrant position; cosine is one quadrant ahead
    assign q_sel  = (r_state == S_VCOS) ? (r_q + 2'd1) : r_q;
    assign tab_ix = q_sel[0] ? (7'd90 - r_r) : r_r;
    assign tv_pos = $signed({1'b0, SIN_TAB[tab_ix][TRIG_FRAC_BITS:0]});
    assign tv     = q_sel[1] ? -tv_pos : tv_pos;

    // rho = trunc toward zero of the Q-sum
    assign sum    = S_W'(r_acc) + S_W'(r_prod);
    assign mag    = sum[S_W-1] ? S_W'(-sum) : S_W'(sum);
    assign rmag   = mag >> TRIG_FRAC_BITS;
    assign rho    = sum[S_W-1] ? -$signed(rmag) : $signed(rmag);
    assign idx    = I_W'(rho) + $signed({{(I_W-8){1'b0}}, r_rho_offset});
    assign idx_ok = !idx[I_W-1] && (idx < I_W'(ROW_COUNT));

    assign rd_addr = (r_state == S_RRD) ? (r_prod[ADDR_W-1:0] + ADDR_W'({8'd0, r_rth}))
                                        : (r_prod[ADDR_W-1:0] + ADDR_W'(t_ext));
    assign inc_val = (mem_rdata == CELL_MAX) ? mem_rdata : (mem_rdata + 1'b1);
    // cell*255 + peak - 1, taken straight off the store port in S_RDAT
    assign div_num = NUM_W'({mem_rdata, 8'd0}) - NUM_W'(mem_rdata) + NUM_W'(r_best_count)
                     - NUM_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_VOTE:  n_state = i_is_black ? S_VCOS : S_DONE;
                        OP_READ:  n_state = S_RCHK;
                        OP_CLEAR: n_state = S_CLEAR;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                if (r_clr == ADDR_W'(CELL_COUNT - 1)) begin
                    n_state = r_reply ? S_DONE : S_IDLE;
                end
            end
            S_VCOS:  n_state = S_VSIN;
            S_VSIN:  n_state = S_VRHO;
            S_VRHO:  n_state = S_VADR;
            S_VADR: begin
                if (r_ok) begin
                    n_state = S_VRD;
                end else begin
                    n_state = last_t ? S_DONE : S_VCOS;
                end
            end
            S_VRD:   n_state = S_VWR;
            S_VWR:   n_state = last_t ? S_DONE : S_VCOS;
            S_RCHK:  n_state = rd_range_bad ? S_DONE : S_RRD;
            S_RRD:   n_state = S_RDAT;
            S_RDAT:  n_state = (r_best_count == '0) ? S_DONE : S_RDIV;
            S_RDIV:  n_state = div_done ? S_DONE : S_RDIV;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs: multiplier operands, store port, divider start
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = inc_val;
        mem_raddr = rd_addr;
        div_start = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_VCOS: begin
                mul_a = tv;
                mul_b = B_W'(r_col);
            end
            S_VSIN: begin
                mul_a = tv;
                mul_b = B_W'(r_row);
            end
            S_VADR: begin
                mul_a = TV_W'(THETA_COUNT);
                mul_b = r_idx;
            end
            S_RCHK: begin
                mul_a = TV_W'(THETA_COUNT);
                mul_b = rrow_ext[B_W-1:0];
            end
            S_VWR:   mem_we = 1'b1;
            S_RDAT:  div_start = (r_best_count != '0);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * $signed({1'b0, mul_b});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_reply      <= 1'b0;
            r_rho_offset <= '0;
            r_best_count <= '0;
            r_best_theta <= '0;
            r_best_rho   <= '0;
            r_voted      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_rho_offset <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= i_op;
                        r_col   <= i_pixel_col;
                        r_row   <= i_pixel_row;
                        r_black <= i_is_black;
                        r_rrow  <= i_read_rho_row;
                        r_rth   <= i_read_theta;
                        r_cell  <= '0;
                        r_shade <= '0;
                        r_err   <= 1'b0;
                        r_t     <= '0;
                        r_q     <= '0;
                        r_r     <= '0;
                        r_clr   <= '0;
                        r_reply <= 1'b1;
                        if (i_op == OP_CLEAR) begin
                            r_best_count <= '0;
                            r_best_theta <= '0;
                            r_best_rho   <= '0;
                            r_voted      <= 1'b0;
                        end
                    end
                end
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_VSIN:  r_acc <= r_prod;
                S_VRHO: begin
                    r_rho <= rho[8:0];
                    r_idx <= idx[B_W-1:0];
                    r_ok  <= idx_ok;
                end
                S_VADR: begin
                    if (!r_ok) begin
                        r_err <= 1'b1;
                        r_t   <= r_t + 1'b1;
                        r_r   <= (r_r == 7'd89) ? 7'd0 : (r_r + 7'd1);
                        r_q   <= (r_r == 7'd89) ? (r_q + 2'd1) : r_q;
                    end
                end
                S_VRD:   r_addr <= rd_addr;
                S_VWR: begin
                    r_voted <= 1'b1;
                    if (inc_val > r_best_count) begin
                        r_best_count <= inc_val;
                        r_best_theta <= t_ext[7:0];
                        r_best_rho   <= r_rho;
                    end
                    r_t <= r_t + 1'b1;
                    r_r <= (r_r == 7'd89) ? 7'd0 : (r_r + 7'd1);
                    r_q <= (r_r == 7'd89) ? (r_q + 2'd1) : r_q;
                end
                S_RCHK: begin
                    if (rd_range_bad) begin
                        r_err   <= 1'b1;
                        r_shade <= 8'(SHADE_MAX);
                    end
                end
                S_RDAT: begin
                    r_cell <= mem_rdata;
                    if (r_best_count == '0) begin
                        r_shade <= 8'(SHADE_MAX);
                    end
                end
                S_RDIV: begin
                    if (div_done) begin
                        r_shade <= (div_quo >= NUM_W'(SHADE_MAX)) ? 8'd0
                                 : (8'(SHADE_MAX) - div_quo[7:0]);
                    end
                end
                default: ;
            endcase
        end
    end

    hlap_store #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (CELL_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    hlap_div #(
        .NUM_W (NUM_W),
        .DEN_W (CELL_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_best_count),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_valid       = (r_state == S_DONE);
    assign o_peak_count  = r_best_count;
    assign o_peak_theta  = r_best_theta;
    assign o_peak_rho    = r_best_rho;
    assign o_any_votes   = r_voted;
    assign o_cell_count  = (r_op == OP_READ) ? r_cell : '0;
    assign o_cell_shade  = r_shade;
    assign o_index_error = r_err && !(r_op == OP_VOTE && !r_black);

    `HLAP_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid,
        "result strobe longer than one cycle")
    `HLAP_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy,
        "block not busy after taking an item")
    `HLAP_ASSERT_NOW(a_idle_no_write, i_clk, i_rst_n, r_state == S_IDLE, !mem_we,
        "store written while idle")
    `HLAP_ASSERT_NOW(a_write_in_range, i_clk, i_rst_n, mem_we,
        mem_waddr < ADDR_W'(CELL_COUNT), "store write beyond last cell")
endmodule
